[design/dtct_pkg.sv]
// Shared types, codes and the lamp decode helper function for the trouble code table.
package dtct_pkg;

  typedef struct packed {
    logic [2:0]  mode;
    logic [18:0] spn;
    logic [4:0]  fmi;
    logic [3:0]  lamp;
    logic [7:0]  requester_addr;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  msg_kind;
    logic [1:0]  status;
    logic [15:0] lamp_bytes;
    logic [31:0] dtc_word;
    logic [7:0]  ack_addr;
    logic        last;
  } result_t;

  // stored code: count in the top bits, key below
  typedef struct packed {
    logic [6:0]  cnt;
    logic [3:0]  lamp;
    logic [4:0]  fmi;
    logic [18:0] spn;
  } entry_t;

  typedef struct packed {
    logic clr;
    logic en;
  } lamp_ctl_t;

  typedef struct packed {
    logic       hit;
    logic [1:0] k;
    logic [1:0] f;
  } lamp_dec_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_MV_RD,
    S_MV_WR,
    S_COMPACT,
    S_COPY,
    S_STATUS,
    S_ACK,
    S_TICK,
    S_LAMP,
    S_SEND,
    S_NEXT
  } state_t;

  localparam logic [2:0] MODE_ACTIVATE     = 3'd0;
  localparam logic [2:0] MODE_DEACTIVATE   = 3'd1;
  localparam logic [2:0] MODE_CLEAR_ACTIVE = 3'd2;
  localparam logic [2:0] MODE_DM3          = 3'd3;
  localparam logic [2:0] MODE_TICK         = 3'd4;

  localparam logic [1:0] KIND_STATUS  = 2'd0;
  localparam logic [1:0] KIND_DM1     = 2'd1;
  localparam logic [1:0] KIND_DM2     = 2'd2;
  localparam logic [1:0] KIND_DM3_ACK = 2'd3;

  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_ALREADY   = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  localparam logic [6:0]  CNT_MAX   = 7'h7F;
  localparam logic [6:0]  CNT_ONE   = 7'h01;
  localparam logic [15:0] TIMER_MAX = 16'hFFFF;
  localparam logic [15:0] LAMP_ISO  = 16'hFFFF;

  // flash state per lamp
  localparam logic [1:0] FL_SOLID = 2'd0;
  localparam logic [1:0] FL_SLOW  = 2'd1;
  localparam logic [1:0] FL_FAST  = 2'd2;
  // flash code on the wire
  localparam logic [1:0] FC_SOLID = 2'b11;
  localparam logic [1:0] FC_SLOW  = 2'b00;
  localparam logic [1:0] FC_FAST  = 2'b01;

  localparam int         CFG_W            = 16;
  localparam logic       REG_LAMP_MODE    = 1'b0;
  localparam logic       REG_MIN_INTERVAL = 1'b1;
  localparam logic [15:0] MIN_INTERVAL_RST = 16'd1000;

  function automatic lamp_dec_t lamp_decode(input logic [3:0] l);
    lamp_dec_t d;
    d = '0;
    case (l)
      4'd1:    d = '{hit: 1'b1, k: 2'd0, f: FL_SOLID};
      4'd2:    d = '{hit: 1'b1, k: 2'd0, f: FL_SLOW};
      4'd3:    d = '{hit: 1'b1, k: 2'd0, f: FL_FAST};
      4'd4:    d = '{hit: 1'b1, k: 2'd1, f: FL_SOLID};
      4'd5:    d = '{hit: 1'b1, k: 2'd1, f: FL_SLOW};
      4'd6:    d = '{hit: 1'b1, k: 2'd1, f: FL_FAST};
      4'd7:    d = '{hit: 1'b1, k: 2'd2, f: FL_SOLID};
      4'd8:    d = '{hit: 1'b1, k: 2'd2, f: FL_SLOW};
      4'd9:    d = '{hit: 1'b1, k: 2'd2, f: FL_FAST};
      4'd10:   d = '{hit: 1'b1, k: 2'd3, f: FL_SOLID};
      4'd11:   d = '{hit: 1'b1, k: 2'd3, f: FL_SLOW};
      4'd12:   d = '{hit: 1'b1, k: 2'd3, f: FL_FAST};
      default: d = '0;
    endcase
    return d;
  endfunction

endpackage

[design/dtct_ram.sv]
// Single-port-write, single-read table memory with registered read data.
module dtct_ram #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  dtct_pkg::entry_t wdata,
  input  logic [AW-1:0]    raddr,
  output dtct_pkg::entry_t rdata
);
  import dtct_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/dtct_lamp_acc.sv]
// Lamp status accumulator: folds the lamp codes of one list into DM1/DM2 lamp bytes.
module dtct_lamp_acc (
  input  logic                clk,
  input  dtct_pkg::lamp_ctl_t ctl,
  input  logic [3:0]          lamp,
  output logic [15:0]         lamp_bytes
);
  import dtct_pkg::*;

  logic [3:0] lit;
  logic [1:0] flash [4];
  lamp_dec_t  dec;

  assign dec = lamp_decode(lamp);

  always_ff @(posedge clk) begin
    if (ctl.clr) begin
      lit <= '0;
      for (int k = 0; k < 4; k++) begin
        flash[k] <= FL_SOLID;
      end
    end else if (ctl.en && dec.hit) begin
      lit[dec.k] <= 1'b1;
      // fast wins over slow, slow over solid
      if (dec.f == FL_FAST) begin
        flash[dec.k] <= FL_FAST;
      end else if (dec.f == FL_SLOW && flash[dec.k] != FL_FAST) begin
        flash[dec.k] <= FL_SLOW;
      end
    end
  end

  always_comb begin
    lamp_bytes = '0;
    for (int k = 0; k < 4; k++) begin
      lamp_bytes[2*k]   = lit[k];
      lamp_bytes[2*k+1] = 1'b0;
      case (flash[k])
        FL_SLOW: lamp_bytes[8+2*k +: 2] = FC_SLOW;
        FL_FAST: lamp_bytes[8+2*k +: 2] = FC_FAST;
        default: lamp_bytes[8+2*k +: 2] = FC_SOLID;
      endcase
    end
  end

endmodule

[design/dtct_seq.sv]
// Command sequencer: searches, moves and compacts the two lists and streams reports.
module dtct_seq #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  dtct_pkg::cmd_t    cmd,
  input  logic              lamp_mode,
  input  logic [15:0]       min_interval,
  output logic              result_valid,
  output dtct_pkg::result_t result
);
  import dtct_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  state_t state, state_next;

  cmd_t          cmd_r;
  logic [CW-1:0] acount, icount;
  logic [15:0]   t1, t2;
  logic          pend1, pend2;
  logic [CW-1:0] idx, rj;
  logic          rv;
  logic          found_a, found_i;
  logic [AW-1:0] ai, ii;
  logic [1:0]    st;
  logic          sel;
  logic          send_i;

  // memory ports
  logic          a_we, i_we;
  logic [AW-1:0] a_waddr, i_waddr, a_raddr, i_raddr;
  entry_t        a_wdata, i_wdata, a_rdata, i_rdata;

  lamp_ctl_t     lamp_ctl;
  logic [15:0]   lamp_acc;

  // shared list view
  logic [CW-1:0] list_cnt;
  entry_t        list_rd;
  logic          rd_more, rd_done;
  logic [AW-1:0] idx_addr;
  logic [CW-1:0] scan_j, copy_addr, comp_addr;
  logic [27:0]   cmd_key;
  logic          a_hit, i_hit;
  logic [CW:0]   sum_cnt;

  // decide outcome
  logic          is_act;
  logic [1:0]    dec_st;
  logic          dec_move, dec_append;
  logic [AW-1:0] dec_pos;

  // tick
  logic [15:0]   t1_inc, t2_inc;
  logic          p1, p2;

  // reporting
  logic          more;
  logic          rec_last;
  logic [15:0]   rec_lamps;
  entry_t        moved;

  assign list_cnt  = sel ? icount : acount;
  assign list_rd   = sel ? i_rdata : a_rdata;
  assign rd_more   = idx < list_cnt;
  assign rd_done   = !rd_more && !rv;
  assign idx_addr  = (idx < DEPTH_C) ? idx[AW-1:0] : '0;
  assign scan_j    = idx - 1'b1;
  assign copy_addr = icount + rj;
  assign comp_addr = rj - 1'b1;
  assign cmd_key   = {cmd_r.lamp, cmd_r.fmi, cmd_r.spn};
  assign sum_cnt   = {1'b0, acount} + {1'b0, icount};

  assign a_hit = (idx != '0) && (scan_j < acount) &&
                 ({a_rdata.lamp, a_rdata.fmi, a_rdata.spn} == cmd_key);
  assign i_hit = (idx != '0) && (scan_j < icount) &&
                 ({i_rdata.lamp, i_rdata.fmi, i_rdata.spn} == cmd_key);

  assign is_act = (cmd_r.mode == MODE_ACTIVATE);

  always_comb begin
    dec_st     = ST_DONE;
    dec_move   = 1'b0;
    dec_append = 1'b0;
    dec_pos    = is_act ? ii : ai;
    if (is_act) begin
      if (found_a) begin
        dec_st = ST_ALREADY;
      end else if (acount >= DEPTH_C) begin
        dec_st = ST_FULL;
      end else if (found_i) begin
        dec_move = 1'b1;
      end else begin
        dec_append = 1'b1;
      end
    end else begin
      if (found_i) begin
        dec_st = ST_ALREADY;
      end else if (!found_a) begin
        dec_st = ST_NOT_FOUND;
      end else if (icount >= DEPTH_C) begin
        dec_st = ST_FULL;
      end else begin
        dec_move = 1'b1;
      end
    end
  end

  always_comb begin
    t1_inc = (t1 < TIMER_MAX) ? t1 + 16'd1 : t1;
    t2_inc = (t2 < TIMER_MAX) ? t2 + 16'd1 : t2;
    p1 = pend1 || ((lamp_mode || acount != '0) && t1_inc >= min_interval);
    p2 = pend2 || ((lamp_mode || icount != '0) && t2_inc >= min_interval);
  end

  always_comb begin
    moved = i_rdata;
    if (i_rdata.cnt != CNT_MAX) begin
      moved.cnt = i_rdata.cnt + 7'd1;
    end
  end

  assign more      = !sel && send_i;
  assign rec_last  = (rj == list_cnt - 1'b1) && !more;
  assign rec_lamps = lamp_mode ? lamp_acc : LAMP_ISO;
  assign busy      = (state != S_IDLE);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          case (cmd.mode)
            MODE_ACTIVATE, MODE_DEACTIVATE: state_next = S_SCAN;
            MODE_CLEAR_ACTIVE: state_next = (sum_cnt > {1'b0, DEPTH_C}) ? S_STATUS : S_COPY;
            MODE_DM3:          state_next = S_ACK;
            MODE_TICK:         state_next = S_TICK;
            default:           state_next = S_STATUS;
          endcase
        end
      end
      S_SCAN:    if (idx == DEPTH_C) state_next = S_DECIDE;
      S_DECIDE:  state_next = dec_move ? S_MV_RD : S_STATUS;
      S_MV_RD:   state_next = S_MV_WR;
      S_MV_WR:   state_next = S_COMPACT;
      S_COMPACT: if (rd_done) state_next = S_STATUS;
      S_COPY:    if (rd_done) state_next = S_STATUS;
      S_STATUS:  state_next = S_IDLE;
      S_ACK:     state_next = S_IDLE;
      S_TICK: begin
        if (p1 || p2) begin
          state_next = lamp_mode ? S_LAMP : S_SEND;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_LAMP:    if (rd_done) state_next = S_SEND;
      S_SEND: begin
        if (list_cnt == '0 || rd_done) begin
          state_next = more ? S_NEXT : S_IDLE;
        end
      end
      S_NEXT:    state_next = lamp_mode ? S_LAMP : S_SEND;
      default:   state_next = S_IDLE;
    endcase
  end

  // memory and accumulator control
  always_comb begin
    a_we     = 1'b0;
    i_we     = 1'b0;
    a_waddr  = acount[AW-1:0];
    i_waddr  = icount[AW-1:0];
    a_wdata  = i_rdata;
    i_wdata  = a_rdata;
    a_raddr  = idx_addr;
    i_raddr  = idx_addr;
    lamp_ctl = '{clr: 1'b0, en: 1'b0};
    case (state)
      S_DECIDE: begin
        if (dec_append) begin
          a_we    = 1'b1;
          a_wdata = '{cnt: CNT_ONE, lamp: cmd_r.lamp, fmi: cmd_r.fmi, spn: cmd_r.spn};
        end
      end
      S_MV_RD: begin
        a_raddr = ai;
        i_raddr = ii;
      end
      S_MV_WR: begin
        if (is_act) begin
          a_we    = 1'b1;
          a_wdata = moved;
        end else begin
          i_we    = 1'b1;
        end
      end
      S_COMPACT: begin
        // shift the tail down by one over the removed slot
        if (sel) begin
          i_we    = rv;
          i_waddr = comp_addr[AW-1:0];
          i_wdata = i_rdata;
        end else begin
          a_we    = rv;
          a_waddr = comp_addr[AW-1:0];
          a_wdata = a_rdata;
        end
      end
      S_COPY: begin
        i_we    = rv;
        i_waddr = copy_addr[AW-1:0];
        i_wdata = a_rdata;
      end
      S_TICK, S_NEXT: lamp_ctl.clr = 1'b1;
      S_LAMP:         lamp_ctl.en  = rv;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      acount       <= '0;
      icount       <= '0;
      t1           <= '0;
      t2           <= '0;
      pend1        <= 1'b0;
      pend2        <= 1'b0;
      rv           <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            cmd_r   <= cmd;
            idx     <= '0;
            rv      <= 1'b0;
            found_a <= 1'b0;
            found_i <= 1'b0;
            sel     <= 1'b0;
            st      <= ST_DONE;
            if (cmd.mode == MODE_CLEAR_ACTIVE && sum_cnt > {1'b0, DEPTH_C}) begin
              st <= ST_FULL;
            end
          end
        end
        S_SCAN: begin
          if (idx != DEPTH_C) begin
            idx <= idx + 1'b1;
          end
          if (a_hit && !found_a) begin
            found_a <= 1'b1;
            ai      <= scan_j[AW-1:0];
          end
          if (i_hit && !found_i) begin
            found_i <= 1'b1;
            ii      <= scan_j[AW-1:0];
          end
        end
        S_DECIDE: begin
          st <= dec_st;
          if (dec_append) begin
            acount <= acount + 1'b1;
            if (t1 > min_interval) begin
              pend1 <= 1'b1;
              t1    <= '0;
            end
          end
          sel <= is_act;
          idx <= CW'(dec_pos) + 1'b1;
          rv  <= 1'b0;
        end
        S_MV_WR: begin
          if (is_act) begin
            acount <= acount + 1'b1;
          end else begin
            icount <= icount + 1'b1;
            if (t2 > min_interval) begin
              pend2 <= 1'b1;
              t2    <= '0;
            end
          end
        end
        S_COMPACT, S_COPY, S_LAMP, S_SEND: begin
          rv <= rd_more;
          rj <= idx;
          if (rd_more) begin
            idx <= idx + 1'b1;
          end
          if (state == S_COMPACT && rd_done) begin
            if (sel) begin
              icount <= icount - 1'b1;
            end else begin
              acount <= acount - 1'b1;
            end
          end
          if (state == S_COPY && rd_done) begin
            icount <= icount + acount;
            acount <= '0;
          end
          if (state == S_LAMP && rd_done) begin
            idx <= '0;
            rv  <= 1'b0;
          end
          if (state == S_SEND) begin
            if (list_cnt == '0) begin
              // empty list: one record with no code
              result_valid <= 1'b1;
              result <= '{msg_kind: sel ? KIND_DM2 : KIND_DM1, status: ST_DONE,
                          lamp_bytes: rec_lamps, dtc_word: '0, ack_addr: '0,
                          last: !more};
            end else if (rv) begin
              result_valid <= 1'b1;
              result <= '{msg_kind: sel ? KIND_DM2 : KIND_DM1, status: ST_DONE,
                          lamp_bytes: rec_lamps,
                          dtc_word: {1'b0, list_rd.cnt, list_rd.spn[18:16], list_rd.fmi,
                                     list_rd.spn[15:0]},
                          ack_addr: '0, last: rec_last};
            end
          end
        end
        S_STATUS: begin
          result_valid <= 1'b1;
          result <= '{msg_kind: KIND_STATUS, status: st, lamp_bytes: '0, dtc_word: '0,
                      ack_addr: '0, last: 1'b1};
        end
        S_ACK: begin
          icount       <= '0;
          result_valid <= 1'b1;
          result <= '{msg_kind: KIND_DM3_ACK, status: ST_DONE, lamp_bytes: '0,
                      dtc_word: '0, ack_addr: cmd_r.requester_addr, last: 1'b1};
        end
        S_TICK: begin
          t1     <= p1 ? '0 : t1_inc;
          t2     <= p2 ? '0 : t2_inc;
          pend1  <= 1'b0;
          pend2  <= 1'b0;
          send_i <= p2;
          sel    <= !p1;
          idx    <= '0;
          rv     <= 1'b0;
        end
        S_NEXT: begin
          sel <= 1'b1;
          idx <= '0;
          rv  <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  dtct_ram #(.DEPTH(TABLE_DEPTH), .AW(AW)) u_active (
    .clk   (clk),
    .we    (a_we),
    .waddr (a_waddr),
    .wdata (a_wdata),
    .raddr (a_raddr),
    .rdata (a_rdata)
  );

  dtct_ram #(.DEPTH(TABLE_DEPTH), .AW(AW)) u_inactive (
    .clk   (clk),
    .we    (i_we),
    .waddr (i_waddr),
    .wdata (i_wdata),
    .raddr (i_raddr),
    .rdata (i_rdata)
  );

  dtct_lamp_acc u_lamp (
    .clk        (clk),
    .ctl        (lamp_ctl),
    .lamp       (list_rd.lamp),
    .lamp_bytes (lamp_acc)
  );

  a_acount_bound: assert property (@(posedge clk) disable iff (rst)
    acount <= DEPTH_C) else $error("active count above table depth");

  a_icount_bound: assert property (@(posedge clk) disable iff (rst)
    icount <= DEPTH_C) else $error("inactive count above table depth");

  a_last_gap: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.last |=> !result_valid)
    else $error("word after final word of a command");

  a_ack_single: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.msg_kind == KIND_DM3_ACK |-> result.last)
    else $error("DM3 acknowledge not final");

  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !rv) else $error("read pipeline busy in idle");

endmodule

[design/diagnostic_trouble_code_table_unit.sv]
// Top level of the trouble code table: configuration registers and the sequencer.
//
// Usage: drive a command word on cmd and pulse start while busy is low; the
// command is taken at that edge and busy rises for its duration. Results come
// back on result, one word per cycle while a list's records are sent, each
// marked by result_valid for exactly one cycle; result.last flags the final
// word of a command. There is no stall: the receiver must take every word.
// Configuration (lamp_mode, min_interval_ms) is written through cfg_we /
// cfg_index / cfg_data; the user must write it only while no command is in
// flight, and the block itself does not enforce this. Command steps:
//   activate / deactivate: a table search, a decide step and a status word;
//   when an entry moves, a read, a write and compaction of its old list come
//   before the status word; the table search reads both memories one entry
//   per cycle, compaction moves one entry per cycle. Clear active: a copy
//   pass over the active list, then the status word (the status word alone
//   when the lists do not fit). DM3 request and unknown modes: one word.
//   Tick: a check; then, per list sent, its records (one when empty),
//   preceded in J1939 mode by a lamp pass, and a step between the two lists.
// Reset empties both lists, zeroes timers and pending sends, and restores
// lamp_mode = 0, min_interval_ms = 1000. Memory contents are not cleared.
module diagnostic_trouble_code_table_unit #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  dtct_pkg::cmd_t           cmd,
  output logic                     result_valid,
  output dtct_pkg::result_t        result,
  input  logic                     cfg_we,
  input  logic                     cfg_index,
  input  logic [dtct_pkg::CFG_W-1:0] cfg_data
);
  import dtct_pkg::*;

  logic        lamp_mode;
  logic [15:0] min_interval;

  always_ff @(posedge clk) begin
    if (rst) begin
      lamp_mode    <= 1'b0;
      min_interval <= MIN_INTERVAL_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LAMP_MODE:    lamp_mode    <= cfg_data[0];
        REG_MIN_INTERVAL: min_interval <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  dtct_seq #(.TABLE_DEPTH(TABLE_DEPTH)) u_seq (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .cmd          (cmd),
    .lamp_mode    (lamp_mode),
    .min_interval (min_interval),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule

[dv/tb_top.sv]
// Self-checking testbench for the trouble code table: directed rows, a count saturation run, then random command words.
module tb_top;
  import dtct_pkg::*;

  localparam int DEPTH    = 16;
  localparam int SETTLE   = 60;
  localparam int WD_LIMIT = 4000;
  localparam logic [2:0] MODE_BAD_LO = 3'd5;
  localparam logic [2:0] MODE_BAD_HI = 3'd7;

  typedef struct {
    cmd_t    c;
    bit      typed;
    result_t r;
  } dir_row_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  cmd_t              cmd = '0;
  logic              result_valid;
  result_t           result;
  logic              cfg_we = 1'b0;
  logic              cfg_index = 1'b0;
  logic [CFG_W-1:0]  cfg_data = '0;

  diagnostic_trouble_code_table_unit #(.TABLE_DEPTH(DEPTH)) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .result_valid(result_valid), .result(result),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // shadow table state
  entry_t  act_tab[DEPTH];
  entry_t  ina_tab[DEPTH];
  int      act_n, ina_n;
  int      dm1_ms, dm2_ms;
  bit      dm1_pend, dm2_pend;
  bit      lamps_on;
  int      min_ms;

  result_t pending_words[$];
  int      errors = 0;
  int      quiet = 0;
  cmd_t    code_pool[24];

  function automatic int find_code(input entry_t l[DEPTH], input int n, input cmd_t c);
    for (int i = 0; i < n; i++)
      if (l[i].spn == c.spn && l[i].fmi == c.fmi && l[i].lamp == c.lamp) return i;
    return -1;
  endfunction

  function automatic logic [15:0] lamp_summary(input entry_t l[DEPTH], input int n);
    logic [7:0] on_b, fl_b;
    int fl, v;
    bit lit;
    on_b = '0;
    fl_b = '0;
    for (int k = 0; k < 4; k++) begin
      lit = 0;
      fl = 0;
      for (int i = 0; i < n; i++) begin
        v = int'(l[i].lamp);
        if (v >= 1 && v <= 12 && (v - 1) / 3 == k) begin
          lit = 1;
          if ((v - 1) % 3 == 2) fl = 2;
          else if ((v - 1) % 3 == 1 && fl != 2) fl = 1;
        end
      end
      on_b[2*k +: 2] = lit ? 2'b01 : 2'b00;
      fl_b[2*k +: 2] = (fl == 2) ? FC_FAST : (fl == 1) ? FC_SLOW : FC_SOLID;
    end
    return {fl_b, on_b};
  endfunction

  function automatic result_t mk_res(input logic [1:0] k, input logic [1:0] s,
                                     input logic [15:0] lb, input logic [31:0] w,
                                     input logic [7:0] a);
    result_t r;
    r = '{msg_kind: k, status: s, lamp_bytes: lb, dtc_word: w, ack_addr: a, last: 1'b0};
    return r;
  endfunction

  task automatic emit_list(input entry_t l[DEPTH], input int n, input logic [1:0] k,
                           inout result_t q[$]);
    logic [15:0] lb;
    lb = lamps_on ? lamp_summary(l, n) : LAMP_ISO;
    if (n == 0) q = {q, mk_res(k, ST_DONE, lb, '0, '0)};
    for (int i = 0; i < n; i++)
      q = {q, mk_res(k, ST_DONE, lb,
                     {1'b0, l[i].cnt, l[i].spn[18:16], l[i].fmi, l[i].spn[15:0]}, '0)};
  endtask

  task automatic predict_words(input cmd_t c, output result_t q[$]);
    int ai, ii;
    logic [1:0] st;
    entry_t e;
    q = {};
    st = ST_DONE;
    ai = find_code(act_tab, act_n, c);
    ii = find_code(ina_tab, ina_n, c);
    case (c.mode)
      MODE_ACTIVATE: begin
        if (ai >= 0) st = ST_ALREADY;
        else if (act_n >= DEPTH) st = ST_FULL;
        else if (ii >= 0) begin
          e = ina_tab[ii];
          if (e.cnt != CNT_MAX) e.cnt++;
          for (int i = ii; i < ina_n - 1; i++) ina_tab[i] = ina_tab[i+1];
          ina_n--;
          act_tab[act_n++] = e;
        end else begin
          act_tab[act_n++] = '{cnt: CNT_ONE, lamp: c.lamp, fmi: c.fmi, spn: c.spn};
          if (dm1_ms > min_ms) begin
            dm1_pend = 1;
            dm1_ms = 0;
          end
        end
        q = {q, mk_res(KIND_STATUS, st, '0, '0, '0)};
      end
      MODE_DEACTIVATE: begin
        if (ii >= 0) st = ST_ALREADY;
        else if (ai < 0) st = ST_NOT_FOUND;
        else if (ina_n >= DEPTH) st = ST_FULL;
        else begin
          e = act_tab[ai];
          for (int i = ai; i < act_n - 1; i++) act_tab[i] = act_tab[i+1];
          act_n--;
          ina_tab[ina_n++] = e;
          if (dm2_ms > min_ms) begin
            dm2_pend = 1;
            dm2_ms = 0;
          end
        end
        q = {q, mk_res(KIND_STATUS, st, '0, '0, '0)};
      end
      MODE_CLEAR_ACTIVE: begin
        if (act_n + ina_n > DEPTH) st = ST_FULL;
        else begin
          for (int i = 0; i < act_n; i++) ina_tab[ina_n++] = act_tab[i];
          act_n = 0;
        end
        q = {q, mk_res(KIND_STATUS, st, '0, '0, '0)};
      end
      MODE_DM3: begin
        ina_n = 0;
        q = {q, mk_res(KIND_DM3_ACK, ST_DONE, '0, '0, c.requester_addr)};
      end
      MODE_TICK: begin
        if (dm1_ms < TIMER_MAX) dm1_ms++;
        if (dm2_ms < TIMER_MAX) dm2_ms++;
        if ((lamps_on || act_n != 0) && dm1_ms >= min_ms) begin
          dm1_pend = 1;
          dm1_ms = 0;
        end
        if ((lamps_on || ina_n != 0) && dm2_ms >= min_ms) begin
          dm2_pend = 1;
          dm2_ms = 0;
        end
        if (dm1_pend) begin
          emit_list(act_tab, act_n, KIND_DM1, q);
          dm1_pend = 0;
          dm1_ms = 0;
        end
        if (dm2_pend) begin
          emit_list(ina_tab, ina_n, KIND_DM2, q);
          dm2_pend = 0;
          dm2_ms = 0;
        end
      end
      default: q = {q, mk_res(KIND_STATUS, ST_DONE, '0, '0, '0)};
    endcase
    if (q.size() > 0) q[q.size()-1].last = 1'b1;
  endtask

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
    errors++;
  endtask

  // result word check
  always @(posedge clk) begin
    result_t w;
    if (!rst && result_valid) begin
      if (pending_words.size() == 0) begin
        report("unexpected word", result.dtc_word, 32'd0);
      end else begin
        w = pending_words.pop_front();
        if (result.msg_kind !== w.msg_kind)
          report("msg_kind", 32'(result.msg_kind), 32'(w.msg_kind));
        if (result.status !== w.status)
          report("status", 32'(result.status), 32'(w.status));
        if (result.lamp_bytes !== w.lamp_bytes)
          report("lamp_bytes", 32'(result.lamp_bytes), 32'(w.lamp_bytes));
        if (result.dtc_word !== w.dtc_word) report("dtc_word", result.dtc_word, w.dtc_word);
        if (result.ack_addr !== w.ack_addr)
          report("ack_addr", 32'(result.ack_addr), 32'(w.ack_addr));
        if (result.last !== w.last) report("last", 32'(result.last), 32'(w.last));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WD_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic issue(input cmd_t c, input bit typed, input result_t r);
    result_t q[$];
    start <= 1'b1;
    cmd <= c;
    do @(posedge clk); while (busy);
    predict_words(c, q);
    if (typed) begin
      r.last = 1'b1;
      q = '{r};
    end
    pending_words = {pending_words, q};
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input int v);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v[CFG_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_LAMP_MODE) lamps_on = v[0];
    else min_ms = v & 16'hFFFF;
  endtask

  function automatic cmd_t mk_cmd(input logic [2:0] m, input logic [18:0] s,
                                  input logic [4:0] f, input logic [3:0] l,
                                  input logic [7:0] a);
    cmd_t c;
    c = '{mode: m, spn: s, fmi: f, lamp: l, requester_addr: a};
    return c;
  endfunction

  function automatic cmd_t rand_cmd();
    cmd_t c;
    int p;
    p = $urandom_range(99);
    c = ($urandom_range(9) == 0)
        ? mk_cmd(MODE_ACTIVATE, 19'($urandom), 5'($urandom), 4'($urandom), 8'($urandom))
        : code_pool[$urandom_range(23)];
    c.requester_addr = 8'($urandom);
    if (p < 32) c.mode = MODE_ACTIVATE;
    else if (p < 56) c.mode = MODE_DEACTIVATE;
    else if (p < 61) c.mode = MODE_CLEAR_ACTIVE;
    else if (p < 65) c.mode = MODE_DM3;
    else if (p < 96) c.mode = MODE_TICK;
    else c.mode = 3'($urandom_range(MODE_BAD_LO, MODE_BAD_HI));
    return c;
  endfunction

  initial begin
    dir_row_t rows[14];
    result_t  none;
    int       idle_pct[4];
    int       lim;
    none = '0;
    act_n = 0;
    ina_n = 0;
    dm1_ms = 0;
    dm2_ms = 0;
    dm1_pend = 0;
    dm2_pend = 0;
    lamps_on = 0;
    min_ms = 1000;
    for (int i = 0; i < 24; i++)
      code_pool[i] = mk_cmd(MODE_ACTIVATE, 19'($urandom), 5'($urandom),
                            4'($urandom_range(15)), 8'd0);
    code_pool[0] = mk_cmd(MODE_ACTIVATE, 19'h7FFFF, 5'd31, 4'd15, 8'd0);
    code_pool[1] = mk_cmd(MODE_ACTIVATE, '0, '0, '0, 8'd0);

    rows[0]  = '{mk_cmd(MODE_DEACTIVATE, 19'd42, 5'd3, 4'd1, 8'd0), 1'b1,
                 mk_res(KIND_STATUS, ST_NOT_FOUND, '0, '0, '0)};
    rows[1]  = '{mk_cmd(MODE_ACTIVATE, 19'h7FFFF, 5'd31, 4'd12, 8'd0), 1'b1,
                 mk_res(KIND_STATUS, ST_DONE, '0, '0, '0)};
    rows[2]  = '{mk_cmd(MODE_ACTIVATE, 19'h7FFFF, 5'd31, 4'd12, 8'd0), 1'b1,
                 mk_res(KIND_STATUS, ST_ALREADY, '0, '0, '0)};
    rows[3]  = '{mk_cmd(MODE_ACTIVATE, '0, '0, '0, 8'hFF), 1'b0, none};
    rows[4]  = '{mk_cmd(MODE_ACTIVATE, 19'h2AAAA, 5'd10, 4'd13, 8'd0), 1'b0, none};
    rows[5]  = '{mk_cmd(MODE_DEACTIVATE, 19'h7FFFF, 5'd31, 4'd12, 8'd0), 1'b1,
                 mk_res(KIND_STATUS, ST_DONE, '0, '0, '0)};
    rows[6]  = '{mk_cmd(MODE_DEACTIVATE, 19'h7FFFF, 5'd31, 4'd12, 8'd0), 1'b1,
                 mk_res(KIND_STATUS, ST_ALREADY, '0, '0, '0)};
    rows[7]  = '{mk_cmd(MODE_ACTIVATE, 19'h7FFFF, 5'd31, 4'd12, 8'd0), 1'b0, none};
    rows[8]  = '{mk_cmd(MODE_BAD_LO, 19'h55555, 5'd21, 4'd5, 8'd0), 1'b1,
                 mk_res(KIND_STATUS, ST_DONE, '0, '0, '0)};
    rows[9]  = '{mk_cmd(MODE_BAD_HI, '0, '0, '0, 8'd0), 1'b1,
                 mk_res(KIND_STATUS, ST_DONE, '0, '0, '0)};
    rows[10] = '{mk_cmd(MODE_TICK, '0, '0, '0, 8'd0), 1'b0, none};
    rows[11] = '{mk_cmd(MODE_DM3, '0, '0, '0, 8'hFF), 1'b1,
                 mk_res(KIND_DM3_ACK, ST_DONE, '0, '0, 8'hFF)};
    rows[12] = '{mk_cmd(MODE_DM3, '0, '0, '0, 8'h00), 1'b1,
                 mk_res(KIND_DM3_ACK, ST_DONE, '0, '0, 8'h00)};
    rows[13] = '{mk_cmd(MODE_CLEAR_ACTIVE, '0, '0, '0, 8'd0), 1'b0, none};

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (rows[i]) issue(rows[i].c, rows[i].typed, rows[i].r);

    // reactivate one code until its count saturates, then report it
    write_reg(REG_MIN_INTERVAL, 65535);
    for (int i = 0; i < 130; i++) begin
      issue(mk_cmd(MODE_ACTIVATE, 19'h12345, 5'd7, 4'd9, 8'd0), 1'b0, none);
      issue(mk_cmd(MODE_DEACTIVATE, 19'h12345, 5'd7, 4'd9, 8'd0), 1'b0, none);
    end
    issue(mk_cmd(MODE_ACTIVATE, 19'h12345, 5'd7, 4'd9, 8'd0), 1'b0, none);
    write_reg(REG_MIN_INTERVAL, 1);
    issue(mk_cmd(MODE_TICK, '0, '0, '0, 8'd0), 1'b0, none);
    write_reg(REG_LAMP_MODE, 1);
    issue(mk_cmd(MODE_TICK, '0, '0, '0, 8'd0), 1'b0, none);

    // sender idle share per phase; the receiver cannot stall
    idle_pct = '{0, 62, 0, 23};
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(REG_LAMP_MODE, int'($urandom_range(1)));
      lim = (ph == 3) ? 65535 : (ph == 0) ? 1 : int'($urandom_range(2, 12));
      write_reg(REG_MIN_INTERVAL, lim);
      for (int n = 0; n < 55; n++) begin
        issue(rand_cmd(), 1'b0, none);
        if (n == 30) drain();
        else if ($urandom_range(99) < idle_pct[ph]) begin
          start <= 1'b0;
          repeat ($urandom_range(1, 8)) @(posedge clk);
        end
      end
    end

    drain();
    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end
endmodule
